// ----- hw/rtl/lvlh_eci_frame_rotation_top_macros.svh -----
// ---------------------------------------------------------------------------
// LVLH/ECI frame rotation assertion macros
// Shared property forms for the frame rotation block. Each expects clk and
// rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef LVLH_ECI_FRAME_ROTATION_TOP_MACROS_SVH
`define LVLH_ECI_FRAME_ROTATION_TOP_MACROS_SVH

// Same-cycle implication.
`define LEROT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define LEROT_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lerot_pkg.sv -----
// ---------------------------------------------------------------------------
// LVLH/ECI frame rotation package
// Widths, latencies and shared types of the frame rotation pipeline.
// ---------------------------------------------------------------------------
package lerot_pkg;

    localparam int UNIT_FRAC_BITS = 30;
    localparam int UW = UNIT_FRAC_BITS + 2;
    localparam int WW = 32;
    localparam int VW = 64;
    localparam int CW = 31;
    localparam int SW = 64;
    localparam int RW = 32;
    localparam int SRW = RW + 2;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = UNIT_FRAC_BITS + 2;
    localparam int NUMW = CW + UNIT_FRAC_BITS + 1;
    localparam int NORM_LAT = 7 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int TOTAL_LAT = 2 * NORM_LAT + 6;

    typedef logic signed [WW-1:0] word_t;
    typedef logic signed [UW-1:0] unit_t;
    typedef logic signed [VW-1:0] nvec_t;

    typedef enum logic [0:0] {
        CMD_TO_ECI  = 1'b0,
        CMD_TO_LVLH = 1'b1
    } cmd_e;

    typedef struct packed {
        logic  valid;
        nvec_t v0;
        nvec_t v1;
        nvec_t v2;
    } norm_in_t;

    typedef struct packed {
        logic  valid;
        logic  nonzero;
        unit_t u0;
        unit_t u1;
        unit_t u2;
    } norm_out_t;

    typedef struct packed {
        cmd_e  cmd;
        word_t x;
        word_t y;
        word_t z;
    } side_t;

endpackage

// ----- hw/rtl/lerot_norm.sv -----
// ---------------------------------------------------------------------------
// LVLH/ECI frame rotation normalizer
// Pipelined unit-vector unit: magnitude scaling, square root and three
// restoring dividers, one step per stage.
// ---------------------------------------------------------------------------
module lerot_norm
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lerot_pkg::norm_in_t  din,
    output lerot_pkg::norm_out_t dout
);

    localparam int F = lerot_pkg::UNIT_FRAC_BITS;
    localparam int VW = lerot_pkg::VW;
    localparam int CW = lerot_pkg::CW;
    localparam int SW = lerot_pkg::SW;
    localparam int RW = lerot_pkg::RW;
    localparam int SRW = lerot_pkg::SRW;
    localparam int NS = lerot_pkg::SQRT_STEPS;
    localparam int Q = lerot_pkg::DIV_STEPS;
    localparam int NUMW = lerot_pkg::NUMW;
    localparam int UW = lerot_pkg::UW;

    typedef logic [VW-1:0] mag_t;
    typedef logic [CW-1:0] comp_t;

    typedef struct packed {
        logic       nz;
        logic [2:0] neg;
        comp_t      c0;
        comp_t      c1;
        comp_t      c2;
    } carry_t;

    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    mag_t       mg1_reg [3];
    mag_t       mg2_reg [3];
    mag_t       mg3_reg [3];
    mag_t       mg4_reg [3];
    logic [2:0] neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg, neg7_reg;
    mag_t       m2_reg;
    logic [7:0] nz3_reg;
    logic [2:0] hi3_reg [8];
    logic [6:0] b4_reg;
    comp_t      c5_reg [3];
    comp_t      c6_reg [3];
    comp_t      c7_reg [3];
    logic       nz5_reg, nz6_reg, nz7_reg;
    logic [2*CW-1:0] sq6_reg [3];
    logic [SW-1:0]   s7_reg;

    mag_t       m2_next;
    logic [7:0] nz3_next;
    logic [2:0] hi3_next [8];
    logic [6:0] b4_next;
    logic [6:0] sh5;
    comp_t      c5_next [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= din.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_comb
    begin
        m2_next = mg1_reg[0];
        if (mg1_reg[1] > m2_next)
        begin
            m2_next = mg1_reg[1];
        end
        if (mg1_reg[2] > m2_next)
        begin
            m2_next = mg1_reg[2];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            nz3_next[k] = |m2_reg[8*k +: 8];
            hi3_next[k] = 3'd0;
            for (int j = 0; j < 8; j++)
            begin
                if (m2_reg[8*k + j])
                begin
                    hi3_next[k] = 3'(j);
                end
            end
        end
    end

    always_comb
    begin
        b4_next = 7'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (nz3_reg[k])
            begin
                b4_next = 7'(8 * k) + 7'(hi3_reg[k]) + 7'd1;
            end
        end
    end

    always_comb
    begin
        if (b4_reg > 7'(CW))
        begin
            sh5 = b4_reg - 7'(CW);
            for (int i = 0; i < 3; i++)
            begin
                c5_next[i] = comp_t'(mg4_reg[i] >> sh5);
            end
        end
        else
        begin
            sh5 = 7'(CW) - b4_reg;
            for (int i = 0; i < 3; i++)
            begin
                c5_next[i] = comp_t'(mg4_reg[i] << sh5);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mg1_reg[0] <= din.v0[VW-1] ? mag_t'(-din.v0) : mag_t'(din.v0);
        mg1_reg[1] <= din.v1[VW-1] ? mag_t'(-din.v1) : mag_t'(din.v1);
        mg1_reg[2] <= din.v2[VW-1] ? mag_t'(-din.v2) : mag_t'(din.v2);
        neg1_reg <= {din.v2[VW-1], din.v1[VW-1], din.v0[VW-1]};
        m2_reg <= m2_next;
        mg2_reg <= mg1_reg;
        neg2_reg <= neg1_reg;
        nz3_reg <= nz3_next;
        hi3_reg <= hi3_next;
        mg3_reg <= mg2_reg;
        neg3_reg <= neg2_reg;
        b4_reg <= b4_next;
        mg4_reg <= mg3_reg;
        neg4_reg <= neg3_reg;
        c5_reg <= c5_next;
        nz5_reg <= (b4_reg != 7'd0);
        neg5_reg <= neg4_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq6_reg[i] <= (2*CW)'(c5_reg[i]) * (2*CW)'(c5_reg[i]);
        end
        c6_reg <= c5_reg;
        nz6_reg <= nz5_reg;
        neg6_reg <= neg5_reg;
        s7_reg <= SW'(sq6_reg[0]) + SW'(sq6_reg[1]) + SW'(sq6_reg[2]);
        c7_reg <= c6_reg;
        nz7_reg <= nz6_reg;
        neg7_reg <= neg6_reg;
    end

    logic           sq_v    [0:NS];
    carry_t         sq_cr   [0:NS];
    logic [SRW-1:0] sq_rem  [0:NS];
    logic [RW-1:0]  sq_root [0:NS];
    logic [SW-1:0]  sq_s    [0:NS];

    assign sq_v[0] = v7_reg;
    assign sq_cr[0] = '{nz: nz7_reg, neg: neg7_reg, c0: c7_reg[0], c1: c7_reg[1],
                        c2: c7_reg[2]};
    assign sq_rem[0] = '0;
    assign sq_root[0] = '0;
    assign sq_s[0] = s7_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        logic [SRW+1:0] t;
        logic [SRW+1:0] trial;

        assign t = {sq_rem[k], sq_s[k][SW-1-2*k -: 2]};
        assign trial = {2'b00, sq_root[k], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v[k+1] <= 1'b0;
            end
            else
            begin
                sq_v[k+1] <= sq_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_cr[k+1] <= sq_cr[k];
            sq_s[k+1] <= sq_s[k];
            if (t >= trial)
            begin
                sq_rem[k+1] <= SRW'(t - trial);
                sq_root[k+1] <= {sq_root[k][RW-2:0], 1'b1};
            end
            else
            begin
                sq_rem[k+1] <= t[SRW-1:0];
                sq_root[k+1] <= {sq_root[k][RW-2:0], 1'b0};
            end
        end
    end

    logic            dv_v   [0:Q];
    logic            dv_nz  [0:Q];
    logic [2:0]      dv_neg [0:Q];
    logic [RW-1:0]   dv_n   [0:Q];
    logic [NUMW-1:0] dv_num [0:Q][3];
    logic [RW-1:0]   dv_rem [0:Q][3];
    logic [Q-1:0]    dv_q   [0:Q][3];

    logic [NUMW-1:0] num0 [3];
    logic [RW-1:0]   root_f;

    assign root_f = sq_root[NS];
    assign num0[0] = NUMW'({sq_cr[NS].c0, {F{1'b0}}}) + NUMW'(root_f[RW-1:1]);
    assign num0[1] = NUMW'({sq_cr[NS].c1, {F{1'b0}}}) + NUMW'(root_f[RW-1:1]);
    assign num0[2] = NUMW'({sq_cr[NS].c2, {F{1'b0}}}) + NUMW'(root_f[RW-1:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v[0] <= 1'b0;
        end
        else
        begin
            dv_v[0] <= sq_v[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_nz[0] <= sq_cr[NS].nz;
        dv_neg[0] <= sq_cr[NS].neg;
        dv_n[0] <= root_f;
        for (int i = 0; i < 3; i++)
        begin
            dv_num[0][i] <= num0[i];
            dv_rem[0][i] <= RW'(num0[i][NUMW-1:Q]);
            dv_q[0][i] <= '0;
        end
    end

    for (genvar k = 0; k < Q; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v[k+1] <= 1'b0;
            end
            else
            begin
                dv_v[k+1] <= dv_v[k];
            end
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [RW:0] t;

            assign t = {dv_rem[k][i], dv_num[k][i][Q-1-k]};

            always_ff @(posedge clk)
            begin
                dv_num[k+1][i] <= dv_num[k][i];
                if (t >= {1'b0, dv_n[k]})
                begin
                    dv_rem[k+1][i] <= RW'(t - {1'b0, dv_n[k]});
                    dv_q[k+1][i] <= {dv_q[k][i][Q-2:0], 1'b1};
                end
                else
                begin
                    dv_rem[k+1][i] <= t[RW-1:0];
                    dv_q[k+1][i] <= {dv_q[k][i][Q-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            dv_nz[k+1] <= dv_nz[k];
            dv_neg[k+1] <= dv_neg[k];
            dv_n[k+1] <= dv_n[k];
        end
    end

    logic                    out_valid_reg;
    logic                    out_nz_reg;
    lerot_pkg::unit_t        out_u_reg [3];
    lerot_pkg::unit_t        out_u_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (!dv_nz[Q])
            begin
                out_u_next[i] = '0;
            end
            else if (dv_neg[Q][i])
            begin
                out_u_next[i] = lerot_pkg::unit_t'(UW'(0) - UW'(dv_q[Q][i]));
            end
            else
            begin
                out_u_next[i] = lerot_pkg::unit_t'(dv_q[Q][i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= dv_v[Q];
        end
    end

    always_ff @(posedge clk)
    begin
        out_nz_reg <= dv_nz[Q];
        out_u_reg <= out_u_next;
    end

    assign dout = '{valid: out_valid_reg, nonzero: out_nz_reg, u0: out_u_reg[0],
                    u1: out_u_reg[1], u2: out_u_reg[2]};

endmodule

// ----- hw/rtl/lvlh_eci_frame_rotation_top.sv -----
// ---------------------------------------------------------------------------
// LVLH/ECI frame rotation
// Takes one request per clock: busy is always low and every request with
// start high is taken. Its result appears on out_x, out_y, out_z and
// degenerate with done high for one cycle. The result path runs through
// two normalizers in series, each with a 32-step square root followed by
// a divider of fraction-bits-plus-two steps. The receiver cannot stall.
// ---------------------------------------------------------------------------
`include "lvlh_eci_frame_rotation_top_macros.svh"

module lvlh_eci_frame_rotation_top
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    command,
    input  lerot_pkg::word_t        in_x,
    input  lerot_pkg::word_t        in_y,
    input  lerot_pkg::word_t        in_z,
    input  lerot_pkg::word_t        pos_x,
    input  lerot_pkg::word_t        pos_y,
    input  lerot_pkg::word_t        pos_z,
    input  lerot_pkg::word_t        vel_x,
    input  lerot_pkg::word_t        vel_y,
    input  lerot_pkg::word_t        vel_z,
    output logic                    done,
    output lerot_pkg::word_t        out_x,
    output lerot_pkg::word_t        out_y,
    output lerot_pkg::word_t        out_z,
    output logic                    degenerate
);

    localparam int NL = lerot_pkg::NORM_LAT;
    localparam int F = lerot_pkg::UNIT_FRAC_BITS;
    localparam int UW = lerot_pkg::UW;

    typedef struct packed {
        lerot_pkg::side_t side;
        logic             par;
    } s1_t;

    typedef struct packed {
        lerot_pkg::side_t side;
        logic             ok1;
        lerot_pkg::unit_t ax0;
        lerot_pkg::unit_t ax1;
        lerot_pkg::unit_t ax2;
        lerot_pkg::unit_t az0;
        lerot_pkg::unit_t az1;
        lerot_pkg::unit_t az2;
    } s2_t;

    function automatic lerot_pkg::word_t round_sat(input logic signed [63:0] acc);
        logic [63:0] m;
        logic [63:0] r;
        m = acc[63] ? 64'(-acc) : 64'(acc);
        r = (m + (64'(1) << (F - 1))) >> F;
        if (acc[63])
        begin
            if (r > 64'h8000_0000)
            begin
                r = 64'h8000_0000;
            end
            return lerot_pkg::word_t'(32'd0 - r[31:0]);
        end
        if (r > 64'h7FFF_FFFF)
        begin
            r = 64'h7FFF_FFFF;
        end
        return lerot_pkg::word_t'(r[31:0]);
    endfunction

    assign busy = 1'b0;

    logic                 a0_valid_reg, a1_valid_reg, a2_valid_reg;
    lerot_pkg::side_t     a0_side_reg, a1_side_reg, a2_side_reg;
    lerot_pkg::word_t     a0_pos_reg [3];
    lerot_pkg::word_t     a0_vel_reg [3];
    logic signed [63:0]   a1_pv_reg [6];
    logic                 a2_par_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_valid_reg <= 1'b0;
            a1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
        end
        else
        begin
            a0_valid_reg <= start & ~busy;
            a1_valid_reg <= a0_valid_reg;
            a2_valid_reg <= a1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a0_side_reg <= '{cmd: lerot_pkg::cmd_e'(command), x: in_x, y: in_y, z: in_z};
        a0_pos_reg[0] <= pos_x;
        a0_pos_reg[1] <= pos_y;
        a0_pos_reg[2] <= pos_z;
        a0_vel_reg[0] <= vel_x;
        a0_vel_reg[1] <= vel_y;
        a0_vel_reg[2] <= vel_z;
        a1_side_reg <= a0_side_reg;
        a1_pv_reg[0] <= 64'(a0_pos_reg[1]) * 64'(a0_vel_reg[2]);
        a1_pv_reg[1] <= 64'(a0_pos_reg[2]) * 64'(a0_vel_reg[1]);
        a1_pv_reg[2] <= 64'(a0_pos_reg[2]) * 64'(a0_vel_reg[0]);
        a1_pv_reg[3] <= 64'(a0_pos_reg[0]) * 64'(a0_vel_reg[2]);
        a1_pv_reg[4] <= 64'(a0_pos_reg[0]) * 64'(a0_vel_reg[1]);
        a1_pv_reg[5] <= 64'(a0_pos_reg[1]) * 64'(a0_vel_reg[0]);
        a2_side_reg <= a1_side_reg;
        a2_par_reg <= (a1_pv_reg[0] == a1_pv_reg[1]) && (a1_pv_reg[2] == a1_pv_reg[3])
                      && (a1_pv_reg[4] == a1_pv_reg[5]);
    end

    lerot_pkg::norm_in_t  np_in, nv_in, nc_in;
    lerot_pkg::norm_out_t np_out, nv_out, nc_out;

    assign np_in = '{valid: a0_valid_reg,
                     v0: lerot_pkg::nvec_t'(a0_pos_reg[0]),
                     v1: lerot_pkg::nvec_t'(a0_pos_reg[1]),
                     v2: lerot_pkg::nvec_t'(a0_pos_reg[2])};
    assign nv_in = '{valid: a0_valid_reg,
                     v0: lerot_pkg::nvec_t'(a0_vel_reg[0]),
                     v1: lerot_pkg::nvec_t'(a0_vel_reg[1]),
                     v2: lerot_pkg::nvec_t'(a0_vel_reg[2])};

    lerot_norm u_norm_pos
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (np_in),
        .dout  (np_out)
    );

    lerot_norm u_norm_vel
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (nv_in),
        .dout  (nv_out)
    );

    s1_t dl1_reg [NL-2];

    always_ff @(posedge clk)
    begin
        dl1_reg[0] <= '{side: a2_side_reg, par: a2_par_reg};
        for (int k = 1; k < NL - 2; k++)
        begin
            dl1_reg[k] <= dl1_reg[k-1];
        end
    end

    s1_t              s1_out;
    lerot_pkg::unit_t az [3];
    lerot_pkg::unit_t ax [3];
    logic             ok1;

    assign s1_out = dl1_reg[NL-3];
    assign ax[0] = nv_out.u0;
    assign ax[1] = nv_out.u1;
    assign ax[2] = nv_out.u2;
    assign az[0] = lerot_pkg::unit_t'(-np_out.u0);
    assign az[1] = lerot_pkg::unit_t'(-np_out.u1);
    assign az[2] = lerot_pkg::unit_t'(-np_out.u2);
    assign ok1 = np_out.nonzero & nv_out.nonzero & ~s1_out.par;

    logic                   x1_valid_reg, x2_valid_reg;
    s2_t                    x1_s_reg, x2_s_reg;
    logic signed [2*UW-1:0] x1_pr_reg [6];
    lerot_pkg::nvec_t       x2_cr_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_valid_reg <= 1'b0;
            x2_valid_reg <= 1'b0;
        end
        else
        begin
            x1_valid_reg <= np_out.valid;
            x2_valid_reg <= x1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_s_reg <= '{side: s1_out.side, ok1: ok1, ax0: ax[0], ax1: ax[1], ax2: ax[2],
                      az0: az[0], az1: az[1], az2: az[2]};
        x1_pr_reg[0] <= az[1] * ax[2];
        x1_pr_reg[1] <= az[2] * ax[1];
        x1_pr_reg[2] <= az[2] * ax[0];
        x1_pr_reg[3] <= az[0] * ax[2];
        x1_pr_reg[4] <= az[0] * ax[1];
        x1_pr_reg[5] <= az[1] * ax[0];
        x2_s_reg <= x1_s_reg;
        x2_cr_reg[0] <= lerot_pkg::nvec_t'(x1_pr_reg[0]) - lerot_pkg::nvec_t'(x1_pr_reg[1]);
        x2_cr_reg[1] <= lerot_pkg::nvec_t'(x1_pr_reg[2]) - lerot_pkg::nvec_t'(x1_pr_reg[3]);
        x2_cr_reg[2] <= lerot_pkg::nvec_t'(x1_pr_reg[4]) - lerot_pkg::nvec_t'(x1_pr_reg[5]);
    end

    assign nc_in = '{valid: x2_valid_reg, v0: x2_cr_reg[0], v1: x2_cr_reg[1],
                     v2: x2_cr_reg[2]};

    lerot_norm u_norm_cross
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (nc_in),
        .dout  (nc_out)
    );

    s2_t dl2_reg [NL];

    always_ff @(posedge clk)
    begin
        dl2_reg[0] <= x2_s_reg;
        for (int k = 1; k < NL; k++)
        begin
            dl2_reg[k] <= dl2_reg[k-1];
        end
    end

    s2_t              s2_out;
    lerot_pkg::unit_t axis [3][3];
    lerot_pkg::unit_t coef [3][3];
    lerot_pkg::word_t vec [3];

    assign s2_out = dl2_reg[NL-1];
    assign vec[0] = s2_out.side.x;
    assign vec[1] = s2_out.side.y;
    assign vec[2] = s2_out.side.z;

    always_comb
    begin
        axis[0][0] = s2_out.ax0;
        axis[0][1] = s2_out.ax1;
        axis[0][2] = s2_out.ax2;
        axis[1][0] = nc_out.u0;
        axis[1][1] = nc_out.u1;
        axis[1][2] = nc_out.u2;
        axis[2][0] = s2_out.az0;
        axis[2][1] = s2_out.az1;
        axis[2][2] = s2_out.az2;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (s2_out.side.cmd == lerot_pkg::CMD_TO_ECI)
                begin
                    coef[i][j] = axis[j][i];
                end
                else
                begin
                    coef[i][j] = axis[i][j];
                end
            end
        end
    end

    logic               r1_valid_reg, r2_valid_reg, done_reg;
    logic               r1_ok_reg, r2_ok_reg, degen_reg;
    logic signed [63:0] r1_pr_reg [3][3];
    logic signed [63:0] r2_acc_reg [3];
    lerot_pkg::word_t   out_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            r1_valid_reg <= nc_out.valid;
            r2_valid_reg <= r1_valid_reg;
            done_reg <= r2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r1_ok_reg <= s2_out.ok1 & nc_out.nonzero;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r1_pr_reg[i][j] <= 64'(vec[j]) * 64'(coef[i][j]);
            end
        end
        r2_ok_reg <= r1_ok_reg;
        for (int i = 0; i < 3; i++)
        begin
            r2_acc_reg[i] <= r1_pr_reg[i][0] + r1_pr_reg[i][1] + r1_pr_reg[i][2];
        end
        degen_reg <= ~r2_ok_reg;
        for (int i = 0; i < 3; i++)
        begin
            out_reg[i] <= r2_ok_reg ? round_sat(r2_acc_reg[i]) : '0;
        end
    end

    assign done = done_reg;
    assign degenerate = degen_reg;
    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];

    `LEROT_ASSERT_DELAY(a_latency, start && !busy, lerot_pkg::TOTAL_LAT, done, "request did not complete on time")
    `LEROT_ASSERT_IMPL(a_degen_zero, done && degenerate, out_x == 0 && out_y == 0 && out_z == 0, "degenerate result is not zero")
    `LEROT_ASSERT_DELAY(a_zero_pos, start && !busy && pos_x == 0 && pos_y == 0 && pos_z == 0, lerot_pkg::TOTAL_LAT, done && degenerate, "zero position not flagged degenerate")

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// LVLH/ECI frame rotation testbench
// Drives position, velocity and vector requests into the rotation pipeline.
// It predicts each result from its own fixed-point model of the frame build
// and the rotation, and checks every done pulse against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = lerot_pkg::TOTAL_LAT + 20;

    typedef longint vec3_t [3];

    typedef struct {
        lerot_pkg::cmd_e  cmd;
        lerot_pkg::word_t iv [3];
        lerot_pkg::word_t pv [3];
        lerot_pkg::word_t vv [3];
        bit               drain;
    } request_t;

    typedef struct {
        lerot_pkg::word_t x;
        lerot_pkg::word_t y;
        lerot_pkg::word_t z;
        bit               degen;
    } rotation_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             command;
    lerot_pkg::word_t in_x, in_y, in_z;
    lerot_pkg::word_t pos_x, pos_y, pos_z;
    lerot_pkg::word_t vel_x, vel_y, vel_z;
    logic             done;
    lerot_pkg::word_t out_x, out_y, out_z;
    logic             degenerate;

    request_t  pending_q [$];
    rotation_t rotation_q [$];
    request_t  cur_req;
    logic      taken;
    int        sent_count;
    int        error_count = 0;
    int        quiet_cycles;

    lvlh_eci_frame_rotation_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .in_x(in_x), .in_y(in_y), .in_z(in_z),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit [63:0] int_sqrt(bit [63:0] s);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit make_unit(input vec3_t v, output vec3_t u);
        bit [63:0] mg [3];
        bit [63:0] m;
        bit [63:0] s;
        bit [63:0] n;
        bit [63:0] q;
        int r;
        int l;
        m = 0;
        s = 0;
        r = 0;
        l = 0;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
            if (mg[i] > m)
                m = mg[i];
        end
        if (m == 0)
        begin
            u = '{0, 0, 0};
            return 1'b0;
        end
        while ((m >> r) >= 64'h8000_0000)
            r++;
        m = m >> r;
        while ((m << l) < 64'h4000_0000)
            l++;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = (mg[i] >> r) << l;
            s = s + mg[i] * mg[i];
        end
        n = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mg[i] << lerot_pkg::UNIT_FRAC_BITS) + (n >> 1)) / n;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic lerot_pkg::word_t round_saturate(longint acc);
        bit [63:0] m;
        m = (acc < 0) ? 64'(-acc) : 64'(acc);
        m = (m + (64'd1 << (lerot_pkg::UNIT_FRAC_BITS - 1))) >> lerot_pkg::UNIT_FRAC_BITS;
        if (acc < 0)
        begin
            if (m > 64'h8000_0000)
                m = 64'h8000_0000;
            return lerot_pkg::word_t'(-longint'(m));
        end
        if (m > 64'h7FFF_FFFF)
            m = 64'h7FFF_FFFF;
        return lerot_pkg::word_t'(m);
    endfunction

    function automatic rotation_t rotate_vector(request_t rq);
        vec3_t vec, p, v, up, ax, ay, az, cr;
        longint acc [3];
        bit ok;
        bit ok_v;
        rotation_t res;
        for (int i = 0; i < 3; i++)
        begin
            vec[i] = rq.iv[i];
            p[i] = rq.pv[i];
            v[i] = rq.vv[i];
        end
        ok = make_unit(p, up);
        ok_v = make_unit(v, ax);
        ok = ok && ok_v;
        if (ok && p[1] * v[2] == p[2] * v[1] && p[2] * v[0] == p[0] * v[2] &&
            p[0] * v[1] == p[1] * v[0])
            ok = 1'b0;
        if (ok)
        begin
            for (int i = 0; i < 3; i++)
                az[i] = -up[i];
            cr[0] = az[1] * ax[2] - az[2] * ax[1];
            cr[1] = az[2] * ax[0] - az[0] * ax[2];
            cr[2] = az[0] * ax[1] - az[1] * ax[0];
            ok = make_unit(cr, ay);
        end
        if (!ok)
        begin
            res = '{0, 0, 0, 1'b1};
            return res;
        end
        if (rq.cmd == lerot_pkg::CMD_TO_ECI)
        begin
            for (int i = 0; i < 3; i++)
                acc[i] = vec[0] * ax[i] + vec[1] * ay[i] + vec[2] * az[i];
        end
        else
        begin
            acc[0] = vec[0] * ax[0] + vec[1] * ax[1] + vec[2] * ax[2];
            acc[1] = vec[0] * ay[0] + vec[1] * ay[1] + vec[2] * ay[2];
            acc[2] = vec[0] * az[0] + vec[1] * az[1] + vec[2] * az[2];
        end
        res.x = round_saturate(acc[0]);
        res.y = round_saturate(acc[1]);
        res.z = round_saturate(acc[2]);
        res.degen = 1'b0;
        return res;
    endfunction

    function automatic lerot_pkg::word_t random_word();
        case ($urandom_range(3))
            0: return lerot_pkg::word_t'($urandom);
            1: return lerot_pkg::word_t'(int'($urandom_range(200)) - 100);
            2: return $signed($urandom) >>> $urandom_range(31);
            default:
            begin
                case ($urandom_range(4))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    function automatic request_t build_request(lerot_pkg::cmd_e cmd,
                                               lerot_pkg::word_t a0, lerot_pkg::word_t a1,
                                               lerot_pkg::word_t a2, lerot_pkg::word_t p0,
                                               lerot_pkg::word_t p1, lerot_pkg::word_t p2,
                                               lerot_pkg::word_t v0, lerot_pkg::word_t v1,
                                               lerot_pkg::word_t v2);
        request_t rq;
        rq.cmd = cmd;
        rq.iv = '{a0, a1, a2};
        rq.pv = '{p0, p1, p2};
        rq.vv = '{v0, v1, v2};
        rq.drain = 1'b0;
        return rq;
    endfunction

    task automatic add_request(input request_t rq);
        pending_q = {pending_q, rq};
    endtask

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= 1'b0;
            {in_x, in_y, in_z, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z} <= '0;
            sent_count <= 0;
        end
        else if (!start || taken)
        begin
            if (pending_q.size() > 0 && (!pending_q[0].drain || rotation_q.size() == 0) &&
                ((sent_count >= 300 && sent_count < 450) || $urandom_range(99) >= 26))
            begin
                cur_req = pending_q.pop_front();
                command <= cur_req.cmd;
                in_x <= cur_req.iv[0];
                in_y <= cur_req.iv[1];
                in_z <= cur_req.iv[2];
                pos_x <= cur_req.pv[0];
                pos_y <= cur_req.pv[1];
                pos_z <= cur_req.pv[2];
                vel_x <= cur_req.vv[0];
                vel_y <= cur_req.vv[1];
                vel_z <= cur_req.vv[2];
                start <= 1'b1;
                sent_count <= sent_count + 1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        rotation_t exp_rot;
        if (!rst_n)
        begin
            taken <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            taken <= start && !busy;
            if (done)
            begin
                if (rotation_q.size() == 0)
                begin
                    $display("%0t: result with no request pending: %0d %0d %0d deg %0b",
                             $time, out_x, out_y, out_z, degenerate);
                    error_count++;
                end
                else
                begin
                    exp_rot = rotation_q.pop_front();
                    if (out_x !== exp_rot.x || out_y !== exp_rot.y ||
                        out_z !== exp_rot.z || degenerate !== exp_rot.degen)
                    begin
                        $display("%0t: mismatch expected %0d %0d %0d deg %0b, %s",
                                 $time, exp_rot.x, exp_rot.y, exp_rot.z, exp_rot.degen,
                                 $sformatf("got %0d %0d %0d deg %0b",
                                           out_x, out_y, out_z, degenerate));
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                rotation_q = {rotation_q, rotate_vector(cur_req)};
            quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        request_t rq;
        lerot_pkg::word_t big;
        lerot_pkg::word_t neg;
        int k;
        big = 32'sh7FFF_FFFF;
        neg = 32'sh8000_0000;
        rst_n = 1'b0;
        add_request(build_request(lerot_pkg::CMD_TO_ECI, 100, 200, 300, 7000, 0, 0, 0, 7, 0));
        add_request(build_request(lerot_pkg::CMD_TO_LVLH, 100, 200, 300, 7000, 0, 0, 0, 7, 0));
        add_request(build_request(lerot_pkg::CMD_TO_ECI, 5, 6, 7, 0, 0, 0, 1, 2, 3));
        add_request(build_request(lerot_pkg::CMD_TO_LVLH, 5, 6, 7, 1, 2, 3, 0, 0, 0));
        add_request(build_request(lerot_pkg::CMD_TO_ECI, 5, 6, 7, 1, 2, 3, 2, 4, 6));
        add_request(build_request(lerot_pkg::CMD_TO_LVLH, 5, 6, 7, 1, 2, 3, -3, -6, -9));
        add_request(build_request(lerot_pkg::CMD_TO_ECI, 9, 9, 9, big, big, big - 1,
                                  big, big, big));
        add_request(build_request(lerot_pkg::CMD_TO_ECI, big, big, big, big, 0, neg,
                                  0, big, 0));
        add_request(build_request(lerot_pkg::CMD_TO_LVLH, big, big, big, big, big, 0,
                                  neg, big, 3));
        add_request(build_request(lerot_pkg::CMD_TO_ECI, neg, neg, neg, 1, -1, 1,
                                  neg, neg, big));
        add_request(build_request(lerot_pkg::CMD_TO_LVLH, neg, neg, neg, neg, big, neg,
                                  big, 0, neg));
        add_request(build_request(lerot_pkg::CMD_TO_ECI, 1, -1, 1, 1, 0, 0, 0, 0, -1));
        add_request(build_request(lerot_pkg::CMD_TO_LVLH, -1, 1, 0, neg, neg, neg,
                                  big, neg, 0));
        add_request(build_request(lerot_pkg::CMD_TO_ECI, big, neg, 0, big, big, big,
                                  neg, neg, neg));
        add_request(build_request(lerot_pkg::CMD_TO_LVLH, 0, 0, 0, 3, 4, 5, -5, 4, 3));
        for (int i = 0; i < 800; i++)
        begin
            rq = build_request(lerot_pkg::cmd_e'($urandom_range(1)), random_word(),
                               random_word(), random_word(), random_word(), random_word(),
                               random_word(), random_word(), random_word(), random_word());
            case ($urandom_range(19))
                0: rq.pv = '{0, 0, 0};
                1: rq.vv = '{0, 0, 0};
                2:
                begin
                    k = int'($urandom_range(6)) - 3;
                    for (int j = 0; j < 3; j++)
                    begin
                        rq.pv[j] = rq.pv[j] >>> 3;
                        rq.vv[j] = rq.pv[j] * k;
                    end
                end
                default: ;
            endcase
            rq.drain = (i == 200 || i == 600);
            add_request(rq);
        end
        repeat (2) @(posedge clk);
        rst_n = 1'b1;
        while (pending_q.size() > 0 || start || rotation_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
